[sv/assert_macros.svh]
// Assertion macros used by the checker file tct_checker.sv.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tct assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tct assertion failed");

`endif

[sv/tct_pkg.sv]
// Shared types and constants of the touch contact tracker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tct_pkg;

  localparam int SLOTS_DEFAULT = 10;
  localparam int QUEUE_DEPTH   = 2;
  localparam int COORD_W       = 12;
  localparam int SLOT_W        = 4;
  localparam int LIMIT_W       = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_EOR   = 1'b1;

  localparam logic [1:0] EV_BEGIN = 2'd0;
  localparam logic [1:0] EV_MOVE  = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // Register index as decoded from paddr[2].
  localparam logic REG_FINGER_LIMIT = 1'b0;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [SLOT_W-1:0]  contact_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } res_item_t;

  typedef enum logic {
    OP_POINT,
    OP_SCAN
  } q_op_t;

  typedef struct packed {
    q_op_t              op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SLOT_W-1:0]  id;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

[sv/tct_front.sv]
// Front end: accepts transactions, counts points per report, drops bad points.
// Depends on tct_pkg; feeds tct_queue.
`timescale 1ns / 1ps

module tct_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  tct_pkg::in_item_t            item,
  input  logic [tct_pkg::LIMIT_W-1:0]  lim,
  input  tct_pkg::q_stat_t             stat,
  output logic                         busy,
  output logic                         push,
  output tct_pkg::q_entry_t            push_entry
);

  logic [tct_pkg::LIMIT_W-1:0] count;
  logic [tct_pkg::LIMIT_W-1:0] count_next;
  logic                        accept;
  logic                        drop;

  assign busy   = stat.full;
  assign accept = start && !stat.full;

  assign drop = (count >= lim) || (item.contact_number == '0) ||
                (item.contact_number > lim);

  always_comb begin
    push_entry.x  = item.pos_x;
    push_entry.y  = item.pos_y;
    push_entry.id = item.contact_number - tct_pkg::SLOT_W'(1);
    if (item.kind == tct_pkg::KIND_EOR) begin
      push_entry.op = tct_pkg::OP_SCAN;
      push          = accept;
      count_next    = '0;
    end else begin
      push_entry.op = tct_pkg::OP_POINT;
      push          = accept && !drop;
      count_next    = (count == '1) ? count : count + tct_pkg::LIMIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

[sv/tct_queue.sv]
// Short FIFO between the classifying front end and the slot engine.
// Depends on tct_pkg.
`timescale 1ns / 1ps

module tct_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tct_pkg::q_entry_t push_entry,
  input  logic              pop,
  output tct_pkg::q_entry_t head,
  output tct_pkg::q_stat_t  stat
);

  localparam int Depth = tct_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  tct_pkg::q_entry_t mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;

  assign head       = mem[rd_ptr];
  assign stat.full  = (fill == CntW'(Depth));
  assign stat.avail = (fill != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

[sv/tct_back.sv]
// Slot engine: applies points to the slot store and scans for released contacts.
// Depends on tct_pkg; drains tct_queue and drives the result register.
`timescale 1ns / 1ps

module tct_back #(
  parameter int MAX_SLOTS = tct_pkg::SLOTS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tct_pkg::q_entry_t            head,
  input  tct_pkg::q_stat_t             stat,
  input  logic [tct_pkg::LIMIT_W-1:0]  lim,
  output logic                         pop,
  output logic                         res_strobe,
  output tct_pkg::res_item_t           res
);

  localparam int SlotW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                      state;
  logic [tct_pkg::COORD_W-1:0] slot_x [MAX_SLOTS];
  logic [tct_pkg::COORD_W-1:0] slot_y [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]        pressed;
  logic [MAX_SLOTS-1:0]        seen;

  logic [MAX_SLOTS-1:0]        lim_mask;
  logic [MAX_SLOTS-1:0]        pend;
  logic [MAX_SLOTS-1:0]        pick_oh;
  logic [SlotW-1:0]            pick_idx;
  logic [SlotW-1:0]            rd_idx;
  logic [tct_pkg::COORD_W-1:0] rd_x;
  logic [tct_pkg::COORD_W-1:0] rd_y;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      lim_mask[i] = (tct_pkg::LIMIT_W'(i) < lim);
    end
  end

  assign pend    = pressed & ~seen & lim_mask;
  assign pick_oh = pend & (~pend + MAX_SLOTS'(1));

  always_comb begin
    pick_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick_idx = SlotW'(i);
      end
    end
  end

  assign rd_idx = (state == S_SCAN) ? pick_idx : head.id[SlotW-1:0];
  assign rd_x   = slot_x[rd_idx];
  assign rd_y   = slot_y[rd_idx];
  assign pop    = (state == S_IDLE) && stat.avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pressed    <= '0;
      seen       <= '0;
      res_strobe <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_x[i] <= '0;
        slot_y[i] <= '0;
      end
    end else begin
      res_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (stat.avail) begin
            if (head.op == tct_pkg::OP_POINT) begin
              if ((rd_x != head.x) || (rd_y != head.y)) begin
                res_strobe    <= 1'b1;
                res.event_res <= pressed[rd_idx] ? tct_pkg::EV_MOVE : tct_pkg::EV_BEGIN;
                res.out_x     <= head.x;
                res.out_y     <= head.y;
                res.slot      <= head.id;
                res.last      <= 1'b1;
                pressed[rd_idx] <= 1'b1;
              end
              slot_x[rd_idx] <= head.x;
              slot_y[rd_idx] <= head.y;
              seen[rd_idx]   <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pend != '0) begin
            res_strobe    <= 1'b1;
            res.event_res <= tct_pkg::EV_END;
            res.out_x     <= rd_x;
            res.out_y     <= rd_y;
            res.slot      <= tct_pkg::SLOT_W'(pick_idx);
            res.last      <= ((pend & ~pick_oh) == '0);
            pressed[rd_idx] <= 1'b0;
          end else begin
            seen  <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/touch_contact_tracker.sv]
// Top level of the touch contact tracker: APB register, front end, queue, slot engine.
// Depends on tct_pkg, tct_front, tct_queue and tct_back.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low. A point gives at most
// one result in the slot engine; an end of report sends the slot engine into its
// scan state, which gives one touch-end result per released slot in slot order,
// last set on the final one, before it returns to idle.
// A two-entry queue sits in front of the slot engine; busy rises only while it is
// full. Results appear on res for exactly one cycle with res_strobe high and cannot
// be held off. finger_limit (byte address 0) should only be written with the block
// idle.

module touch_contact_tracker #(
  parameter int MAX_SLOTS = tct_pkg::SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tct_pkg::in_item_t  item,
  output logic               res_strobe,
  output tct_pkg::res_item_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [tct_pkg::LIMIT_W-1:0] finger_limit;
  logic [tct_pkg::LIMIT_W-1:0] lim;
  logic                        push;
  logic                        pop;
  tct_pkg::q_entry_t           push_entry;
  tct_pkg::q_entry_t           head;
  tct_pkg::q_stat_t            stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tct_pkg::REG_FINGER_LIMIT) ?
                  {28'd0, finger_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_limit <= tct_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == tct_pkg::REG_FINGER_LIMIT)) begin
      finger_limit <= pwdata[tct_pkg::LIMIT_W-1:0];
    end
  end

  assign lim = (finger_limit > tct_pkg::LIMIT_W'(MAX_SLOTS)) ?
               tct_pkg::LIMIT_W'(MAX_SLOTS) : finger_limit;

  tct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .lim        (lim),
    .stat       (stat),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry)
  );

  tct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  tct_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .stat       (stat),
    .lim        (lim),
    .pop        (pop),
    .res_strobe (res_strobe),
    .res        (res)
  );

endmodule

[sv/tct_checker.sv]
// Port-level checks of the touch contact tracker, bound to the top level.
// Depends on tct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tct_checker #(
  parameter int MAX_SLOTS = tct_pkg::SLOTS_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               res_strobe,
  input tct_pkg::res_item_t res
);

  `TCT_ASSERT_IMPL(a_event_code, clk, rst, res_strobe, (res.event_res == tct_pkg::EV_BEGIN) || (res.event_res == tct_pkg::EV_MOVE) || (res.event_res == tct_pkg::EV_END))
  `TCT_ASSERT_IMPL(a_point_single, clk, rst, res_strobe && (res.event_res != tct_pkg::EV_END), res.last)
  `TCT_ASSERT_NEXT(a_end_burst, clk, rst, res_strobe && !res.last, res_strobe)
  `TCT_ASSERT_IMPL(a_slot_range, clk, rst, res_strobe, res.slot < tct_pkg::SLOT_W'(MAX_SLOTS))
  `TCT_ASSERT_IMPL(a_after_reset, clk, rst, $past(rst), !busy && !res_strobe)

endmodule

bind touch_contact_tracker tct_checker #(
  .MAX_SLOTS (MAX_SLOTS)
) u_tct_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .res_strobe (res_strobe),
  .res        (res)
);

[verif/tb_top.sv]
// Self-checking testbench for touch_contact_tracker: directed and random touch reports.
// A shadow contact tracker predicts begin, move and end events; APB writes set finger_limit.
// Depends on tct_pkg and the touch_contact_tracker RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_SLOTS = tct_pkg::SLOTS_DEFAULT;
  localparam logic [2:0] LIMIT_ADDR = {tct_pkg::REG_FINGER_LIMIT, 2'b00};
  localparam int SETTLE_CYCLES = 30;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  tct_pkg::in_item_t  item = '0;
  logic               res_strobe;
  tct_pkg::res_item_t res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // pending touch items, events still owed by the block
  tct_pkg::in_item_t  pending_items[$];
  tct_pkg::res_item_t expected_events[$];
  int                 n_issued = 0;
  int                 n_accepted = 0;
  int                 n_pushed = 0;
  int                 idle_pct = 31;
  int                 mismatches = 0;
  tct_pkg::res_item_t want_event;

  // shadow tracker state
  logic [tct_pkg::COORD_W-1:0] shadow_x[NUM_SLOTS] = '{default: '0};
  logic [tct_pkg::COORD_W-1:0] shadow_y[NUM_SLOTS] = '{default: '0};
  logic                        shadow_down[NUM_SLOTS] = '{default: 1'b0};
  logic                        shadow_seen[NUM_SLOTS] = '{default: 1'b0};
  logic [3:0]                  shadow_points = '0;
  logic [tct_pkg::LIMIT_W-1:0] shadow_limit = tct_pkg::LIMIT_RESET;
  logic [tct_pkg::LIMIT_W-1:0] cfg_limit = tct_pkg::LIMIT_RESET;

  // last generated position per contact number, to produce unmoved and small moves
  logic [tct_pkg::COORD_W-1:0] recent_x[16] = '{default: '0};
  logic [tct_pkg::COORD_W-1:0] recent_y[16] = '{default: '0};

  touch_contact_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .res_strobe(res_strobe), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  task automatic track_contacts(input tct_pkg::in_item_t it);
    int unsigned        lim;
    int unsigned        id;
    int                 n_rel;
    int                 k;
    logic [3:0]         prior;
    tct_pkg::res_item_t ev;
    lim = (shadow_limit > NUM_SLOTS) ? NUM_SLOTS : shadow_limit;
    if (it.kind == tct_pkg::KIND_POINT) begin
      prior = shadow_points;
      if (shadow_points != 4'd15) shadow_points = shadow_points + 4'd1;
      if (prior >= lim || it.contact_number == 0 || it.contact_number > lim) return;
      id = it.contact_number - 1;
      if (shadow_x[id] != it.pos_x || shadow_y[id] != it.pos_y) begin
        ev.event_res = shadow_down[id] ? tct_pkg::EV_MOVE : tct_pkg::EV_BEGIN;
        ev.out_x = it.pos_x;
        ev.out_y = it.pos_y;
        ev.slot = id[tct_pkg::SLOT_W-1:0];
        ev.last = 1'b1;
        expected_events.push_back(ev);
        shadow_down[id] = 1'b1;
      end
      shadow_x[id] = it.pos_x;
      shadow_y[id] = it.pos_y;
      shadow_seen[id] = 1'b1;
    end else begin
      n_rel = 0;
      for (int i = 0; i < lim; i++)
        if (shadow_down[i] && !shadow_seen[i]) n_rel++;
      k = 0;
      for (int i = 0; i < lim; i++) begin
        if (shadow_down[i] && !shadow_seen[i]) begin
          k++;
          ev.event_res = tct_pkg::EV_END;
          ev.out_x = shadow_x[i];
          ev.out_y = shadow_y[i];
          ev.slot = i[tct_pkg::SLOT_W-1:0];
          ev.last = (k == n_rel);
          expected_events.push_back(ev);
          shadow_down[i] = 1'b0;
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) shadow_seen[i] = 1'b0;
      shadow_points = '0;
    end
  endtask

  task automatic note_mismatch(input string what, input tct_pkg::res_item_t want,
                               input tct_pkg::res_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected ev=%0d x=%0d y=%0d slot=%0d last=%0b, ",
                "got ev=%0d x=%0d y=%0d slot=%0d last=%0b"},
               $realtime, what, want.event_res, want.out_x, want.out_y, want.slot,
               want.last, got.event_res, got.out_x, got.out_y, got.slot, got.last);
  endtask

  // driver: one item in flight, held until taken
  always @(negedge clk) begin
    if (!rst && n_accepted == n_issued) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
        n_issued <= n_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: accepted transactions feed the tracker, events are checked in order
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        track_contacts(item);
        n_accepted++;
      end
      if (res_strobe) begin
        if (expected_events.size() == 0) begin
          note_mismatch("unexpected event", '0, res);
        end else begin
          want_event = expected_events.pop_front();
          if (res.event_res !== want_event.event_res || res.out_x !== want_event.out_x ||
              res.out_y !== want_event.out_y || res.slot !== want_event.slot ||
              res.last !== want_event.last)
            note_mismatch("event mismatch", want_event, res);
        end
      end
    end
  end

  task automatic push_point(input int unsigned cn, input logic [tct_pkg::COORD_W-1:0] x,
                            input logic [tct_pkg::COORD_W-1:0] y);
    tct_pkg::in_item_t it;
    it.kind = tct_pkg::KIND_POINT;
    it.pos_x = x;
    it.pos_y = y;
    it.contact_number = cn[tct_pkg::SLOT_W-1:0];
    recent_x[cn[3:0]] = x;
    recent_y[cn[3:0]] = y;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  task automatic push_end();
    tct_pkg::in_item_t it;
    it.kind = tct_pkg::KIND_EOR;
    it.pos_x = tct_pkg::COORD_W'($urandom_range(4095));
    it.pos_y = tct_pkg::COORD_W'($urandom_range(4095));
    it.contact_number = tct_pkg::SLOT_W'($urandom_range(15));
    pending_items.push_back(it);
    n_pushed++;
  endtask

  // one report: points with mostly valid contacts, then usually an end of report
  task automatic push_report();
    int unsigned                 span;
    int unsigned                 n;
    int unsigned                 cn;
    int unsigned                 roll;
    logic [tct_pkg::COORD_W-1:0] jx;
    logic [tct_pkg::COORD_W-1:0] jy;
    span = (cfg_limit == 0 || cfg_limit > NUM_SLOTS) ? NUM_SLOTS : cfg_limit;
    n = ($urandom_range(99) < 82) ? $urandom_range(span) : $urandom_range(17, span + 1);
    for (int k = 0; k < n; k++) begin
      cn = ($urandom_range(99) < 85) ? $urandom_range(span, 1) : $urandom_range(15);
      roll = $urandom_range(99);
      if (roll < 30) begin
        push_point(cn, recent_x[cn], recent_y[cn]);
      end else if (roll < 60) begin
        jx = tct_pkg::COORD_W'($urandom_range(6));
        jy = tct_pkg::COORD_W'($urandom_range(6));
        push_point(cn, recent_x[cn] + jx - 12'd3, recent_y[cn] + jy - 12'd3);
      end else begin
        push_point(cn, tct_pkg::COORD_W'($urandom_range(4095)),
                   tct_pkg::COORD_W'($urandom_range(4095)));
      end
    end
    if ($urandom_range(99) < 92) push_end();
  endtask

  task automatic run_reports(input int count);
    int target;
    target = n_pushed + count;
    while (n_pushed < target) begin
      if ($urandom_range(99) < 5) push_end();
      push_report();
    end
  endtask

  task automatic wait_quiet();
    while (pending_items.size() > 0 || n_accepted != n_issued || expected_events.size() > 0)
      @(posedge clk);
  endtask

  task automatic drain();
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [tct_pkg::LIMIT_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= {28'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_limit = value;
    cfg_limit = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // unmoved at reset position, begin at corners, bad contact numbers
    push_point(1, 12'd0, 12'd0);
    push_point(1, 12'hFFF, 12'hFFF);
    push_point(10, 12'hFFF, 12'd0);
    push_point(0, 12'd5, 12'd5);
    push_point(11, 12'd5, 12'd5);
    push_point(15, 12'hFFF, 12'hFFF);
    push_end();
    // move then unmoved; slot 9 released
    push_point(1, 12'd100, 12'd200);
    push_point(1, 12'd100, 12'd200);
    push_end();
    // overfull report: eleventh point dropped
    for (int c = 1; c <= 10; c++)
      push_point(c, tct_pkg::COORD_W'($urandom_range(4095)),
                 tct_pkg::COORD_W'($urandom_range(4095)));
    push_point(2, 12'd1, 12'd1);
    push_end();
    // empty report releases every slot
    push_end();
    drain();

    write_limit(4'd1);
    run_reports(40);
    drain();

    write_limit(4'd15);
    run_reports(40);
    wait_quiet();
    run_reports(40);
    drain();

    write_limit(4'd0);
    run_reports(20);
    drain();

    write_limit(4'd5);
    run_reports(60);
    drain();

    write_limit(4'd10);
    idle_pct = 0;
    run_reports(60);
    wait_quiet();
    idle_pct = 31;
    run_reports(50);
    drain();

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/tct_pkg.sv
sv/tct_front.sv
sv/tct_queue.sv
sv/tct_back.sv
sv/touch_contact_tracker.sv
sv/tct_checker.sv
verif/tb_top.sv
